@@ hw/rtl/pngrf_pkg.sv @@
// ----------------------------------------------------------------------------
// pngrf_pkg
// shared types, codes and the paeth predictor for the png row filter encoder
// ----------------------------------------------------------------------------
package pngrf_pkg;

    localparam int MAX_BPP_DEFAULT = 8;
    localparam int SUM_W           = 21;
    localparam int CFG_INDEX_W     = 2;
    localparam int CFG_DATA_W      = 8;
    localparam int IN_TDATA_W      = 16;
    localparam int OUT_TDATA_W     = 32;

    localparam logic [CFG_INDEX_W-1:0] CFG_FILTER_TYPE     = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_BYTES_PER_PIXEL = 2'd1;

    localparam logic [2:0] FLT_NONE      = 3'd0;
    localparam logic [2:0] FLT_SUB       = 3'd1;
    localparam logic [2:0] FLT_UP        = 3'd2;
    localparam logic [2:0] FLT_AVG       = 3'd3;
    localparam logic [2:0] FLT_PAETH     = 3'd4;
    localparam logic [2:0] FLT_AVG_FIRST = 3'd5;
    localparam logic [2:0] FLT_PAETH_FIRST = 3'd6;

    localparam logic [2:0] FILTER_RESET = FLT_NONE;
    localparam logic [3:0] BPP_RESET    = 4'd4;

    typedef struct packed {
        logic       valid;
        logic [7:0] cur;
        logic [7:0] up;
    } tap_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] diff;
        logic [7:0] mag;
        logic       last;
    } stage_t;

    function automatic logic [7:0] paeth_pick(input logic [7:0] a, input logic [7:0] b,
                                               input logic [7:0] c);
        logic signed [10:0] pa;
        logic signed [10:0] pb;
        logic signed [10:0] pc;
        pa = $signed({3'b000, b}) - $signed({3'b000, c});
        pb = $signed({3'b000, a}) - $signed({3'b000, c});
        pc = $signed({3'b000, a}) + $signed({3'b000, b}) - $signed({2'b00, c, 1'b0});
        if (pa < 0) pa = -pa;
        if (pb < 0) pb = -pb;
        if (pc < 0) pc = -pc;
        if (pa <= pb && pa <= pc)
            return a;
        else if (pb <= pc)
            return b;
        else
            return c;
    endfunction

endpackage

@@ hw/rtl/pngrf_cell.sv @@
// ----------------------------------------------------------------------------
// pngrf_cell
// one history cell: holds a current byte, the byte above and a row valid flag
// ----------------------------------------------------------------------------
module pngrf_cell
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           shift,
    input  logic           clear,
    input  pngrf_pkg::tap_t tap_in,
    output pngrf_pkg::tap_t tap_out
);
    import pngrf_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] cur_reg;
    logic [7:0] up_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (clear)
        begin
            valid_next = 1'b0;
        end
        else if (shift)
        begin
            valid_next = tap_in.valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            cur_reg <= tap_in.cur;
            up_reg  <= tap_in.up;
        end
    end

    assign tap_out.valid = valid_reg;
    assign tap_out.cur   = cur_reg;
    assign tap_out.up    = up_reg;

endmodule

@@ hw/rtl/pngrf_accum.sv @@
// ----------------------------------------------------------------------------
// pngrf_accum
// row sum accumulator and output register stage
// ----------------------------------------------------------------------------
module pngrf_accum
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  pngrf_pkg::stage_t                     stage,
    output logic                                  take,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [7:0]                            out_diff,
    output logic [pngrf_pkg::SUM_W-1:0]           out_sum,
    output logic                                  out_last
);
    import pngrf_pkg::*;

    logic             valid_reg;
    logic             valid_next;
    logic [SUM_W-1:0] acc_reg;
    logic [SUM_W-1:0] acc_next;
    logic [SUM_W-1:0] sum_sat;
    logic [SUM_W:0]   sum_wide;
    logic [7:0]       diff_reg;
    logic [SUM_W-1:0] sum_reg;
    logic             last_reg;

    assign take     = stage.valid && (!valid_reg || out_ready);
    assign sum_wide = {1'b0, acc_reg} + (SUM_W+1)'(stage.mag);
    assign sum_sat  = sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];

    always_comb
    begin
        valid_next = valid_reg;
        acc_next   = acc_reg;
        if (valid_reg && out_ready)
        begin
            valid_next = 1'b0;
        end
        if (take)
        begin
            valid_next = 1'b1;
            acc_next   = stage.last ? '0 : sum_sat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            acc_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            acc_reg   <= acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            diff_reg <= stage.diff;
            sum_reg  <= sum_sat;
            last_reg <= stage.last;
        end
    end

    assign out_valid = valid_reg;
    assign out_diff  = diff_reg;
    assign out_sum   = sum_reg;
    assign out_last  = last_reg;

`ifndef ASSERT_OFF
    a_acc_cleared_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        take && stage.last |=> acc_reg == '0)
        else $error("row sum not cleared after row end");
    a_sum_not_below_acc: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> sum_reg >= $past(acc_reg))
        else $error("row sum decreased within a row");
`endif

endmodule

@@ hw/rtl/png_row_filter_encoder.sv @@
// ----------------------------------------------------------------------------
// png_row_filter_encoder
// png scanline filter (none, sub, up, average, paeth and first-row forms)
// ----------------------------------------------------------------------------
// One byte per request, one result per request, a new request every cycle
// unless the output stalls. The first stage selects the left and upper-left
// bytes from a chain of history cells and forms the filtered byte; the
// output stage adds its magnitude to the saturating row sum in the output
// register. The chain holds MAX_BYTES_PER_PIXEL cells; tlast on the input
// closes the row and clears the chain and the sum. Configuration writes are
// taken at any time but must only be issued while the block is idle.
// ----------------------------------------------------------------------------
module png_row_filter_encoder
#(
    parameter int MAX_BYTES_PER_PIXEL = pngrf_pkg::MAX_BPP_DEFAULT
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    // cfg_data: filter_type [2:0] or bytes_per_pixel [3:0]
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [pngrf_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [pngrf_pkg::CFG_DATA_W-1:0]     cfg_data,
    // s_tdata: cur_byte [7:0], up_byte [15:8]
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [pngrf_pkg::IN_TDATA_W-1:0]     s_tdata,
    input  logic                                 s_tlast,
    // m_tdata: filtered_byte [7:0], abs_sum [28:8], zero [31:29]
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [pngrf_pkg::OUT_TDATA_W-1:0]    m_tdata,
    output logic                                 m_tlast
);
    import pngrf_pkg::*;

    localparam int IDX_W = (MAX_BYTES_PER_PIXEL > 1) ? $clog2(MAX_BYTES_PER_PIXEL) : 1;
    localparam logic [4:0] MAX_BPP5 = 5'(MAX_BYTES_PER_PIXEL);

    logic [2:0]  filter_reg;
    logic [2:0]  filter_next;
    logic [3:0]  bpp_reg;
    logic [3:0]  bpp_next;

    tap_t        chain_in  [MAX_BYTES_PER_PIXEL];
    tap_t        chain_out [MAX_BYTES_PER_PIXEL];
    logic [MAX_BYTES_PER_PIXEL-1:0] tap_valid;

    logic        in_take;
    logic        row_clear;
    logic [7:0]  cur_byte;
    logic [7:0]  up_byte;
    logic [4:0]  sel5;
    logic [IDX_W-1:0] sel;
    tap_t        tap_sel;
    logic [7:0]  left_byte;
    logic [7:0]  upleft_byte;
    logic [8:0]  avg_sum;
    logic [7:0]  pred;
    logic [7:0]  diff;

    stage_t      s1_reg;
    stage_t      s1_next;
    logic        s1_take;
    logic [SUM_W-1:0] out_sum;
    logic [7:0]  out_diff;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_comb
    begin
        filter_next = filter_reg;
        bpp_next    = bpp_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_FILTER_TYPE:     filter_next = cfg_data[2:0];
                CFG_BYTES_PER_PIXEL: bpp_next    = cfg_data[3:0];
                default:             ;
            endcase
        end
    end

    // input side
    assign cur_byte  = s_tdata[7:0];
    assign up_byte   = s_tdata[15:8];
    assign s_tready  = !s1_reg.valid || s1_take;
    assign in_take   = s_tvalid && s_tready;
    assign row_clear = in_take && s_tlast;

    // history chain
    assign chain_in[0] = '{valid: 1'b1, cur: cur_byte, up: up_byte};

    for (genvar g = 0; g < MAX_BYTES_PER_PIXEL; g++)
    begin : g_cell
        if (g > 0)
        begin : g_link
            assign chain_in[g] = chain_out[g-1];
        end
        pngrf_cell u_cell
        (
            .clk     (clk),
            .rst_n   (rst_n),
            .shift   (in_take),
            .clear   (row_clear),
            .tap_in  (chain_in[g]),
            .tap_out (chain_out[g])
        );
        assign tap_valid[g] = chain_out[g].valid;
    end

    // tap select with pixel size clamped to the chain length
    always_comb
    begin
        if (bpp_reg == 4'd0)
        begin
            sel5 = 5'd0;
        end
        else if ({1'b0, bpp_reg} > MAX_BPP5)
        begin
            sel5 = MAX_BPP5 - 5'd1;
        end
        else
        begin
            sel5 = {1'b0, bpp_reg} - 5'd1;
        end
    end

    assign sel         = sel5[IDX_W-1:0];
    assign tap_sel     = chain_out[sel];
    assign left_byte   = tap_sel.valid ? tap_sel.cur : 8'd0;
    assign upleft_byte = tap_sel.valid ? tap_sel.up : 8'd0;
    assign avg_sum     = {1'b0, left_byte} + {1'b0, up_byte};

    always_comb
    begin
        case (filter_reg)
            FLT_SUB, FLT_PAETH_FIRST: pred = left_byte;
            FLT_UP:                   pred = up_byte;
            FLT_AVG:                  pred = avg_sum[8:1];
            FLT_PAETH:                pred = paeth_pick(left_byte, up_byte, upleft_byte);
            FLT_AVG_FIRST:            pred = {1'b0, left_byte[7:1]};
            default:                  pred = 8'd0;
        endcase
    end

    assign diff = cur_byte - pred;

    // first pipeline stage
    always_comb
    begin
        s1_next = s1_reg;
        if (s1_take)
        begin
            s1_next.valid = 1'b0;
        end
        if (in_take)
        begin
            s1_next.valid = 1'b1;
            s1_next.diff  = diff;
            s1_next.mag   = diff[7] ? 8'(-diff) : diff;
            s1_next.last  = s_tlast;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filter_reg <= FILTER_RESET;
            bpp_reg    <= BPP_RESET;
            s1_reg     <= '0;
        end
        else
        begin
            filter_reg <= filter_next;
            bpp_reg    <= bpp_next;
            s1_reg     <= s1_next;
        end
    end

    pngrf_accum u_accum
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .stage     (s1_reg),
        .take      (s1_take),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_diff  (out_diff),
        .out_sum   (out_sum),
        .out_last  (m_tlast)
    );

    assign m_tdata = {(OUT_TDATA_W - SUM_W - 8)'(0), out_sum, out_diff};

`ifndef ASSERT_OFF
    a_chain_cleared_on_row_end: assert property (@(posedge clk) disable iff (!rst_n)
        in_take && s_tlast |=> tap_valid == '0)
        else $error("history chain not cleared at row end");
    a_chain_head_valid: assert property (@(posedge clk) disable iff (!rst_n)
        in_take && !s_tlast |=> tap_valid[0])
        else $error("history head not marked after a byte");
    a_stage_holds_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        s1_reg.valid && !s1_take |=> s1_reg.valid && $stable(s1_reg.diff))
        else $error("first stage lost or changed a stalled request");
`endif

endmodule
